// ----- sv/rrq_pkg.sv -----
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants of the round-robin ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

    // Widest thread id the command word can carry.
    localparam int ID_MAX_BITS = 16;

    // Opcodes as they arrive on the input stream.
    typedef enum logic [2:0] {
        OP_SCHEDULE = 3'd0,
        OP_READY    = 3'd1,
        OP_KILL     = 3'd2,
        OP_EXIT     = 3'd3,
        OP_RESUME   = 3'd4
    } t_opcode;

    // Command kinds after classification by the front end.
    typedef enum logic [2:0] {
        K_SCHEDULE,
        K_READY,
        K_KILL,
        K_EXIT,
        K_RESUME,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [ID_MAX_BITS-1:0] id;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PASS,
        ST_TAIL,
        ST_CHECK,
        ST_DONE
    } t_bstate;

endpackage

`default_nettype wire

// ----- sv/round_robin_ready_queue.sv -----
// ----------------------------------------------------------------------------
// round_robin_ready_queue
// Round-robin thread scheduler: ordered ready queue plus active thread.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals               Beat contents
//  s        in   i_s_tvalid/o_s_tready  tuser: opcode, tdata: thread_id
//  m        out  o_m_tvalid/i_m_tready  tdata: dispatched, next_thread,
//                                       next_is_idle, overflow, queue_count
//
//  Schedule, ready, an exit with nothing to remove and undefined opcodes go
//  from decode straight to the result state. Resume and kill on a nonempty
//  queue first make a pass over the queue entries. A kill of the active
//  thread that leaves entries adds a rotation pass; each pass does one read
//  and at most one write a cycle. A stalled result holds the sequencer while
//  the two-entry command queue keeps taking beats until it is full. Reset is
//  synchronous and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_ready_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] thread_id
    input  wire logic [2:0]  i_s_tuser,   // [2:0] opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [0] dispatched, [8:1] next_thread,
                                          // [9] next_is_idle, [10] overflow,
                                          // [15:11] queue_count
);
    import rrq_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_full;
    logic w_valid;
    logic w_pop;

    rrq_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    rrq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_cmd   (w_head_cmd)
    );

    rrq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/rrq_front.sv -----
// ----------------------------------------------------------------------------
// rrq_front
// Accepts input beats, classifies the opcode and trims the thread id.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_front #(
    parameter int ID_BITS = 8
) (
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,   // [7:0] thread_id
    input  wire logic [2:0]    i_s_tuser,   // [2:0] opcode
    input  wire logic          i_full,
    output logic               o_push,
    output rrq_pkg::t_cmd      o_cmd
);
    import rrq_pkg::*;

    logic [ID_MAX_BITS+7:0] w_id_ext;
    logic [ID_BITS-1:0]     w_id;
    t_kind                  w_kind;

    assign w_id_ext = {{ID_MAX_BITS{1'b0}}, i_s_tdata};
    assign w_id     = w_id_ext[ID_BITS-1:0];

    always_comb begin
        unique case (t_opcode'(i_s_tuser))
            OP_SCHEDULE: w_kind = K_SCHEDULE;
            OP_READY:    w_kind = K_READY;
            OP_KILL:     w_kind = K_KILL;
            OP_EXIT:     w_kind = K_EXIT;
            OP_RESUME:   w_kind = K_RESUME;
            default:     w_kind = K_NOP;
        endcase
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_cmd.kind = w_kind;
    assign o_cmd.id   = ID_MAX_BITS'(w_id);

endmodule

`default_nettype wire

// ----- sv/rrq_fifo.sv -----
// ----------------------------------------------------------------------------
// rrq_fifo
// Two-entry command queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rrq_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output rrq_pkg::t_cmd      o_cmd
);
    import rrq_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_level, n_level;

    assign o_full  = (r_level == 2'd2);
    assign o_valid = (r_level != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 2'd1;
        end else if (i_pop && !i_push) begin
            n_level = r_level - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_level <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rrq_back.sv -----
// ----------------------------------------------------------------------------
// rrq_back
// Sequencer that owns the ready-queue memory and the active-thread state.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire rrq_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [15:0]        o_m_tdata
);
    import rrq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    t_bstate            r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [ID_BITS-1:0] r_act_id, n_act_id;
    logic               r_act_valid, n_act_valid;
    logic               r_act_idle, n_act_idle;
    t_kind              r_kind, n_kind;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [ID_BITS-1:0] r_kid, n_kid;
    logic               r_rot, n_rot;
    logic [CW-1:0]      r_iss, n_iss;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pend_idx, n_pend_idx;
    logic               r_drop, n_drop;
    logic [ID_BITS-1:0] r_head, n_head;
    logic               r_res_disp, n_res_disp;
    logic [ID_BITS-1:0] r_res_next, n_res_next;
    logic               r_res_idle, n_res_idle;
    logic               r_res_ovf, n_res_ovf;
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_out_data, n_out_data;

    logic [ID_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0] r_rd_data;
    logic               w_we, w_re;
    logic [AW-1:0]      w_wa, w_ra;
    logic [ID_BITS-1:0] w_wd;

    logic               w_pass_end;
    logic               w_kill_hit;
    logic               w_cnt_zero;
    logic               w_slot_free;
    logic [CW-1:0]      w_last;
    logic [AW-1:0]      w_prev;
    logic [ID_BITS+7:0] w_next_ext;
    logic [CW+4:0]      w_cnt_ext;

    assign w_pass_end  = (r_iss == r_cnt) && !r_pend;
    assign w_kill_hit  = r_act_valid && !r_act_idle && (r_act_id == r_kid);
    assign w_cnt_zero  = (r_cnt == '0);
    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_last      = r_cnt - CW'(1);
    assign w_prev      = r_pend_idx - AW'(1);
    assign w_next_ext  = {8'd0, r_res_next};
    assign w_cnt_ext   = {5'd0, r_cnt};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_kind)
                    K_KILL:   n_state = w_cnt_zero ? ST_DONE : ST_PASS;
                    K_RESUME: n_state = w_cnt_zero ? ST_DONE : ST_PASS;
                    K_EXIT: begin
                        // Exit with no active thread or on an empty queue removes nothing and never resumes.
                        if (!r_act_valid || w_cnt_zero) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_PASS;
                        end
                    end
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_PASS: begin
                if (w_pass_end) begin
                    n_state = r_rot ? ST_TAIL : ST_CHECK;
                end
            end
            ST_TAIL: n_state = ST_DONE;
            ST_CHECK: begin
                n_state = (w_kill_hit && !w_cnt_zero) ? ST_PASS : ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory strobes.
    always_comb begin
        n_cnt       = r_cnt;
        n_act_id    = r_act_id;
        n_act_valid = r_act_valid;
        n_act_idle  = r_act_idle;
        n_kind      = r_kind;
        n_id        = r_id;
        n_kid       = r_kid;
        n_rot       = r_rot;
        n_iss       = r_iss;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_drop      = r_drop;
        n_head      = r_head;
        n_res_disp  = r_res_disp;
        n_res_next  = r_res_next;
        n_res_idle  = r_res_idle;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_wa        = '0;
        w_wd        = '0;
        w_re        = 1'b0;
        w_ra        = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_kind     = i_cmd.kind;
                    n_id       = i_cmd.id[ID_BITS-1:0];
                    n_res_disp = 1'b0;
                    n_res_next = '0;
                    n_res_idle = 1'b0;
                    n_res_ovf  = 1'b0;
                end
            end
            ST_DECODE: begin
                n_iss  = '0;
                n_pend = 1'b0;
                n_drop = 1'b0;
                unique case (r_kind)
                    K_SCHEDULE, K_READY: begin
                        if (r_cnt < DEPTH_C) begin
                            w_we  = 1'b1;
                            w_wa  = r_cnt[AW-1:0];
                            w_wd  = r_id;
                            n_cnt = r_cnt + CW'(1);
                        end else begin
                            n_res_ovf = 1'b1;
                        end
                        if (r_kind == K_SCHEDULE) begin
                            n_act_id    = r_id;
                            n_act_valid = 1'b1;
                            n_act_idle  = 1'b0;
                            n_res_disp  = 1'b1;
                            n_res_next  = r_id;
                        end
                    end
                    K_KILL: begin
                        n_rot = 1'b0;
                        n_kid = r_id;
                    end
                    K_EXIT: begin
                        // An idle active thread is never queued: exit just rotates.
                        n_rot = r_act_idle;
                        n_kid = r_act_id;
                    end
                    K_RESUME: begin
                        n_rot = 1'b1;
                        if (w_cnt_zero) begin
                            n_act_id    = '0;
                            n_act_valid = 1'b1;
                            n_act_idle  = 1'b1;
                            n_res_disp  = 1'b1;
                            n_res_next  = '0;
                            n_res_idle  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PASS: begin
                if (r_iss != r_cnt) begin
                    w_re       = 1'b1;
                    w_ra       = r_iss[AW-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_iss[AW-1:0];
                    n_iss      = r_iss + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                // Once an entry is dropped, every later entry moves down one slot.
                if (r_pend) begin
                    if (r_rot && r_pend_idx == '0) begin
                        n_head = r_rd_data;
                        n_drop = 1'b1;
                    end else if (!r_rot && !r_drop && r_rd_data == r_kid) begin
                        n_drop = 1'b1;
                    end else if (r_drop) begin
                        w_we = 1'b1;
                        w_wa = w_prev;
                        w_wd = r_rd_data;
                    end
                end
                if (w_pass_end && !r_rot && r_drop) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_TAIL: begin
                w_we        = 1'b1;
                w_wa        = w_last[AW-1:0];
                w_wd        = r_head;
                n_act_id    = r_head;
                n_act_valid = 1'b1;
                n_act_idle  = 1'b0;
                n_res_disp  = 1'b1;
                n_res_next  = r_head;
                n_res_idle  = 1'b0;
            end
            ST_CHECK: begin
                n_iss  = '0;
                n_pend = 1'b0;
                n_drop = 1'b0;
                n_rot  = 1'b1;
                if (w_kill_hit && w_cnt_zero) begin
                    n_act_id    = '0;
                    n_act_valid = 1'b1;
                    n_act_idle  = 1'b1;
                    n_res_disp  = 1'b1;
                    n_res_next  = '0;
                    n_res_idle  = 1'b1;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {w_cnt_ext[4:0], r_res_ovf, r_res_idle,
                                   w_next_ext[7:0], r_res_disp};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_act_id    <= '0;
            r_act_valid <= 1'b0;
            r_act_idle  <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_act_id    <= n_act_id;
            r_act_valid <= n_act_valid;
            r_act_idle  <= n_act_idle;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_id       <= n_id;
        r_kid      <= n_kid;
        r_rot      <= n_rot;
        r_iss      <= n_iss;
        r_pend_idx <= n_pend_idx;
        r_drop     <= n_drop;
        r_head     <= n_head;
        r_res_disp <= n_res_disp;
        r_res_next <= n_res_next;
        r_res_idle <= n_res_idle;
        r_res_ovf  <= n_res_ovf;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

endmodule

`default_nettype wire

// ----- sv/rrq_checker.sv -----
// ----------------------------------------------------------------------------
// rrq_checker
// Port-level checks on the result stream of the ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rrq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata
);

    localparam logic [4:0] DEPTH_LOW = 5'(QUEUE_DEPTH);
    localparam bit         WRAPS     = (QUEUE_DEPTH >= 31);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> WRAPS || (o_m_tdata[15:11] <= DEPTH_LOW))
        else $error("queue count beyond depth");

    a_idle_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9] |->
            o_m_tdata[0] && (o_m_tdata[8:1] == 8'd0) && (o_m_tdata[15:11] == 5'd0))
        else $error("idle dispatch with queued threads or a thread id");

    a_no_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[8:1] == 8'd0) && !o_m_tdata[9])
        else $error("thread id shown without a dispatch");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10] |-> (o_m_tdata[15:11] == DEPTH_LOW))
        else $error("overflow reported on a queue that is not full");

endmodule

bind round_robin_ready_queue rrq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rrq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
